/* src/lob_pkg.sv */
package lob_pkg;

	localparam int unsigned LEVELS_DEF = 16;
	localparam int unsigned PRICE_W    = 32;
	localparam int unsigned SIZE_W     = 40;
	localparam int unsigned SEQ_W      = 63;
	localparam int unsigned GAP_W      = 32;
	localparam int unsigned OUT_W      = 33;

	typedef enum logic [1:0] {
		KIND_SNAP  = 2'd0,
		KIND_UPD   = 2'd1,
		KIND_SEQ   = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_PUT  = 2'd1,
		OP_DEL  = 2'd2,
		OP_CLR  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [PRICE_W-1:0]  price;
		logic [SIZE_W-1:0]   size;
	} cmd_t;

	typedef struct packed {
		logic                v;
		logic [PRICE_W-1:0]  price;
		logic [SIZE_W-1:0]   size;
	} link_t;

	typedef struct packed {
		logic                valid;
		logic [PRICE_W-1:0]  price;
		logic [SIZE_W-1:0]   size;
		logic                lost;
	} side_stat_t;

endpackage

/* src/lob_cell.sv */
module lob_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  lob_pkg::cmd_t  cmd,
	input  logic           is_bid,
	input  logic           match_any,
	input  lob_pkg::link_t left,
	input  logic           left_ahead,
	input  logic           left_behind,
	input  lob_pkg::link_t right,
	output lob_pkg::link_t link,
	output logic           ahead_v,
	output logic           behind_v,
	output logic           eq_v
);

	logic                          v_q;
	logic [lob_pkg::PRICE_W-1:0]   price_q;
	logic [lob_pkg::SIZE_W-1:0]    size_q;
	logic                          ahead;
	lob_pkg::link_t                cell_d;

	assign ahead    = is_bid ? (price_q > cmd.price) : (price_q < cmd.price);
	assign ahead_v  = v_q && ahead;
	assign behind_v = v_q && !ahead;
	assign eq_v     = v_q && (price_q == cmd.price);

	assign link.v     = v_q;
	assign link.price = price_q;
	assign link.size  = size_q;

	always_comb begin
		cell_d = link;
		case (cmd.op)
			lob_pkg::OP_PUT: begin
				if (match_any) begin
					if (eq_v) begin
						cell_d.size = cmd.size;
					end
				end else if (left_behind) begin
					cell_d = left;
				end else if (!ahead_v && left_ahead) begin
					cell_d.v     = 1'b1;
					cell_d.price = cmd.price;
					cell_d.size  = cmd.size;
				end
			end
			lob_pkg::OP_DEL: begin
				if (match_any && behind_v) begin
					cell_d = right;
				end
			end
			lob_pkg::OP_CLR: begin
				cell_d.v = 1'b0;
			end
			default: begin
				cell_d = link;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= cell_d.v;
		end
	end

	always_ff @(posedge clk) begin
		price_q <= cell_d.price;
		size_q  <= cell_d.size;
	end

endmodule

/* src/lob_side.sv */
module lob_side #(
	parameter int unsigned LEVELS = lob_pkg::LEVELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lob_pkg::cmd_t       cmd,
	input  logic                is_bid,
	output lob_pkg::side_stat_t stat
);

	lob_pkg::link_t    lk [LEVELS];
	logic [LEVELS-1:0] ahead_v;
	logic [LEVELS-1:0] behind_v;
	logic [LEVELS-1:0] eq_v;
	logic              match_any;

	assign match_any = |eq_v;

	for (genvar i = 0; i < LEVELS; i++) begin : g_cell
		lob_pkg::link_t left;
		lob_pkg::link_t right;
		logic           left_ahead;
		logic           left_behind;

		if (i == 0) begin : g_head
			assign left        = '0;
			assign left_ahead  = 1'b1;
			assign left_behind = 1'b0;
		end else begin : g_mid
			assign left        = lk[i-1];
			assign left_ahead  = ahead_v[i-1];
			assign left_behind = behind_v[i-1];
		end

		if (i == LEVELS - 1) begin : g_tail
			assign right = '0;
		end else begin : g_next
			assign right = lk[i+1];
		end

		lob_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.is_bid      (is_bid),
			.match_any   (match_any),
			.left        (left),
			.left_ahead  (left_ahead),
			.left_behind (left_behind),
			.right       (right),
			.link        (lk[i]),
			.ahead_v     (ahead_v[i]),
			.behind_v    (behind_v[i]),
			.eq_v        (eq_v[i])
		);
	end

	assign stat.valid = lk[0].v;
	assign stat.price = lk[0].price;
	assign stat.size  = lk[0].size;
	assign stat.lost  = (cmd.op == lob_pkg::OP_PUT) && !match_any && lk[LEVELS-1].v;

endmodule

/* src/price_level_order_book.sv */
// Price-level order book: a bid side sorted highest first and an ask side
// sorted lowest first, each a chain of LEVELS cells.
// Command channel: an event (kind, price, size, is_bid, seq_first, seq_end)
// is taken at a rising edge with start high and busy low. busy is always
// low, so one event can be taken in every cycle.
// Result channel: done is high for exactly one cycle, in the cycle after the
// event was taken, with best bid and ask, spread, doubled mid, gap count
// and the dropped-level flag for that event on the result ports.
// Throughput is one event per cycle: every cell compares its price with the
// broadcast price and loads itself, the event's price and size, its left
// neighbor or its right neighbor in the same edge.
// The receiver cannot stall; a result not taken in its cycle is lost.
// Reset empties both sides, clears the gap count and forgets the last
// sequence number; no result is pending after reset.
module price_level_order_book #(
	parameter int unsigned LEVELS = lob_pkg::LEVELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         kind,
	input  logic [lob_pkg::PRICE_W-1:0]        price,
	input  logic [lob_pkg::SIZE_W-1:0]         size,
	input  logic                               is_bid,
	input  logic [lob_pkg::SEQ_W-1:0]          seq_first,
	input  logic [lob_pkg::SEQ_W-1:0]          seq_end,
	output logic                               done,
	output logic                               bid_valid,
	output logic [lob_pkg::PRICE_W-1:0]        bid_price,
	output logic [lob_pkg::SIZE_W-1:0]         bid_size,
	output logic                               ask_valid,
	output logic [lob_pkg::PRICE_W-1:0]        ask_price,
	output logic [lob_pkg::SIZE_W-1:0]         ask_size,
	output logic signed [lob_pkg::OUT_W-1:0]   spread_ticks,
	output logic [lob_pkg::OUT_W-1:0]          mid_doubled,
	output logic [lob_pkg::GAP_W-1:0]          gap_total,
	output logic                               level_dropped
);

	logic                          accept;
	lob_pkg::kind_t                kind_e;
	lob_pkg::op_t                  op;
	lob_pkg::cmd_t                 bid_cmd;
	lob_pkg::cmd_t                 ask_cmd;
	lob_pkg::side_stat_t           bid_stat;
	lob_pkg::side_stat_t           ask_stat;
	logic                          gap_hit;
	logic                          lost;

	logic                          done_q;
	logic                          lost_q;
	logic                          seq_known_q;
	logic [lob_pkg::SEQ_W-1:0]     last_seq_q;
	logic [lob_pkg::GAP_W-1:0]     gap_q;

	logic [lob_pkg::OUT_W-1:0]     bp_ext;
	logic [lob_pkg::OUT_W-1:0]     ap_ext;
	logic                          both;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign kind_e = lob_pkg::kind_t'(kind);

	always_comb begin
		case (kind_e)
			lob_pkg::KIND_SNAP:  op = lob_pkg::OP_PUT;
			lob_pkg::KIND_UPD:   op = (size == '0) ? lob_pkg::OP_DEL : lob_pkg::OP_PUT;
			lob_pkg::KIND_SEQ:   op = lob_pkg::OP_NONE;
			lob_pkg::KIND_CLEAR: op = lob_pkg::OP_CLR;
			default:             op = lob_pkg::OP_NONE;
		endcase
	end

	always_comb begin
		bid_cmd.price = price;
		bid_cmd.size  = size;
		ask_cmd.price = price;
		ask_cmd.size  = size;
		bid_cmd.op    = lob_pkg::OP_NONE;
		ask_cmd.op    = lob_pkg::OP_NONE;
		if (accept) begin
			if (op == lob_pkg::OP_CLR) begin
				bid_cmd.op = op;
				ask_cmd.op = op;
			end else if (is_bid) begin
				bid_cmd.op = op;
			end else begin
				ask_cmd.op = op;
			end
		end
	end

	lob_side #(.LEVELS(LEVELS)) u_bid (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (bid_cmd),
		.is_bid (1'b1),
		.stat   (bid_stat)
	);

	lob_side #(.LEVELS(LEVELS)) u_ask (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ask_cmd),
		.is_bid (1'b0),
		.stat   (ask_stat)
	);

	assign lost    = bid_stat.lost || ask_stat.lost;
	assign gap_hit = seq_known_q
		&& ({1'b0, seq_first} > ({1'b0, last_seq_q} + 64'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			lost_q      <= 1'b0;
			seq_known_q <= 1'b0;
			last_seq_q  <= '0;
			gap_q       <= '0;
		end else begin
			done_q <= accept;
			lost_q <= accept && lost;
			if (accept) begin
				case (kind_e)
					lob_pkg::KIND_UPD: begin
						if (gap_hit && (gap_q != '1)) begin
							gap_q <= gap_q + 1'b1;
						end
						last_seq_q  <= seq_end;
						seq_known_q <= 1'b1;
					end
					lob_pkg::KIND_SEQ: begin
						last_seq_q  <= seq_end;
						seq_known_q <= 1'b1;
					end
					lob_pkg::KIND_CLEAR: begin
						last_seq_q  <= '0;
						seq_known_q <= 1'b0;
						gap_q       <= '0;
					end
					default: begin
						seq_known_q <= seq_known_q;
					end
				endcase
			end
		end
	end

	assign both   = bid_stat.valid && ask_stat.valid;
	assign bp_ext = {1'b0, bid_stat.price};
	assign ap_ext = {1'b0, ask_stat.price};

	assign done          = done_q;
	assign bid_valid     = bid_stat.valid;
	assign bid_price     = bid_stat.valid ? bid_stat.price : '0;
	assign bid_size      = bid_stat.valid ? bid_stat.size : '0;
	assign ask_valid     = ask_stat.valid;
	assign ask_price     = ask_stat.valid ? ask_stat.price : '0;
	assign ask_size      = ask_stat.valid ? ask_stat.size : '0;
	assign spread_ticks  = both ? signed'(ap_ext - bp_ext) : '0;
	assign mid_doubled   = both ? (ap_ext + bp_ext) : '0;
	assign gap_total     = gap_q;
	assign level_dropped = lost_q;

`ifndef SYNTHESIS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("result strobe missing after accepted transaction");

	a_drop_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		level_dropped |-> done)
		else $error("dropped flag outside a result");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == lob_pkg::KIND_CLEAR)
		|=> (!bid_valid && !ask_valid && gap_total == '0))
		else $error("clear left book or gap count");

	a_gap_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind != lob_pkg::KIND_CLEAR) |=> gap_total >= $past(gap_total))
		else $error("gap count went down without clear");
`endif

endmodule

/* verif/price_level_order_book_tb.sv */
`timescale 1ns / 100ps

module price_level_order_book_tb;

	localparam int unsigned LEVELS      = lob_pkg::LEVELS_DEF;
	localparam int unsigned PRICE_W     = lob_pkg::PRICE_W;
	localparam int unsigned SIZE_W      = lob_pkg::SIZE_W;
	localparam int unsigned SEQ_W       = lob_pkg::SEQ_W;
	localparam int unsigned GAP_W       = lob_pkg::GAP_W;
	localparam int unsigned OUT_W       = lob_pkg::OUT_W;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned MAX_SHOWN   = 40;

	typedef struct {
		logic [PRICE_W-1:0] price;
		logic [SIZE_W-1:0]  size;
	} level_t;

	typedef struct {
		logic               bid_valid;
		logic [PRICE_W-1:0] bid_price;
		logic [SIZE_W-1:0]  bid_size;
		logic               ask_valid;
		logic [PRICE_W-1:0] ask_price;
		logic [SIZE_W-1:0]  ask_size;
		logic [OUT_W-1:0]   spread;
		logic [OUT_W-1:0]   mid;
		logic [GAP_W-1:0]   gaps;
		logic               dropped;
	} book_view_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [1:0]                kind = lob_pkg::KIND_SNAP;
	logic [PRICE_W-1:0]        price = '0;
	logic [SIZE_W-1:0]         size = '0;
	logic                      is_bid = 1'b0;
	logic [SEQ_W-1:0]          seq_first = '0;
	logic [SEQ_W-1:0]          seq_end = '0;
	logic                      done;
	logic                      bid_valid;
	logic [PRICE_W-1:0]        bid_price;
	logic [SIZE_W-1:0]         bid_size;
	logic                      ask_valid;
	logic [PRICE_W-1:0]        ask_price;
	logic [SIZE_W-1:0]         ask_size;
	logic signed [OUT_W-1:0]   spread_ticks;
	logic [OUT_W-1:0]          mid_doubled;
	logic [GAP_W-1:0]          gap_total;
	logic                      level_dropped;

	// index 1 is the bid side, index 0 the ask side
	level_t             ladder [2][LEVELS];
	int unsigned        ladder_fill [2] = '{0, 0};
	logic [63:0]        last_seq = '0;
	bit                 seq_known = 1'b0;
	logic [GAP_W-1:0]   gap_count = '0;

	book_view_t         views_due [$];
	int unsigned        idle_pct = 0;
	int unsigned        mismatches = 0;
	int unsigned        results_seen = 0;
	int unsigned        idle_cycles = 0;

	price_level_order_book dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] rand_bits64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit place_level(int s, logic [PRICE_W-1:0] p,
			logic [SIZE_W-1:0] sz);
		int  n;
		int  pos;
		bit  lost;
		n = ladder_fill[s];
		pos = 0;
		lost = 1'b0;
		while (pos < n && (s == 1 ? ladder[s][pos].price > p : ladder[s][pos].price < p))
			pos++;
		if (pos < n && ladder[s][pos].price == p) begin
			ladder[s][pos].size = sz;
			return 1'b0;
		end
		if (n >= LEVELS) begin
			if (pos >= LEVELS)
				return 1'b1;
			lost = 1'b1;
			n = LEVELS - 1;
		end
		for (int i = n; i > pos; i--)
			ladder[s][i] = ladder[s][i-1];
		ladder[s][pos].price = p;
		ladder[s][pos].size = sz;
		ladder_fill[s] = n + 1;
		return lost;
	endfunction

	function automatic void remove_level(int s, logic [PRICE_W-1:0] p);
		int n;
		n = ladder_fill[s];
		for (int i = 0; i < n; i++) begin
			if (ladder[s][i].price == p) begin
				for (int j = i; j + 1 < n; j++)
					ladder[s][j] = ladder[s][j+1];
				ladder_fill[s] = n - 1;
				return;
			end
		end
	endfunction

	function automatic book_view_t book_apply(lob_pkg::kind_t k, logic [PRICE_W-1:0] p,
			logic [SIZE_W-1:0] sz, bit bid, logic [SEQ_W-1:0] ss, logic [SEQ_W-1:0] se);
		book_view_t v;
		int         s;
		bit         lost;
		s = bid ? 1 : 0;
		lost = 1'b0;
		case (k)
			lob_pkg::KIND_SNAP: begin
				lost = place_level(s, p, sz);
			end
			lob_pkg::KIND_UPD: begin
				if (seq_known && {1'b0, ss} > last_seq + 64'd1 && gap_count != '1)
					gap_count++;
				if (sz == '0)
					remove_level(s, p);
				else
					lost = place_level(s, p, sz);
				last_seq = {1'b0, se};
				seq_known = 1'b1;
			end
			lob_pkg::KIND_SEQ: begin
				last_seq = {1'b0, se};
				seq_known = 1'b1;
			end
			default: begin
				ladder_fill[0] = 0;
				ladder_fill[1] = 0;
				last_seq = '0;
				seq_known = 1'b0;
				gap_count = '0;
			end
		endcase
		v.bid_valid = ladder_fill[1] != 0;
		v.bid_price = v.bid_valid ? ladder[1][0].price : '0;
		v.bid_size  = v.bid_valid ? ladder[1][0].size : '0;
		v.ask_valid = ladder_fill[0] != 0;
		v.ask_price = v.ask_valid ? ladder[0][0].price : '0;
		v.ask_size  = v.ask_valid ? ladder[0][0].size : '0;
		if (v.bid_valid && v.ask_valid) begin
			v.spread = {1'b0, v.ask_price} - {1'b0, v.bid_price};
			v.mid    = {1'b0, v.ask_price} + {1'b0, v.bid_price};
		end else begin
			v.spread = '0;
			v.mid    = '0;
		end
		v.gaps = gap_count;
		v.dropped = lost;
		return v;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < MAX_SHOWN)
			$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %h want %h",
				results_seen, field, got, want));
	endtask

	task automatic send_event(lob_pkg::kind_t k, logic [PRICE_W-1:0] p,
			logic [SIZE_W-1:0] sz, bit bid, logic [SEQ_W-1:0] ss, logic [SEQ_W-1:0] se);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		kind      <= k;
		price     <= p;
		size      <= sz;
		is_bid    <= bid;
		seq_first <= ss;
		seq_end   <= se;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		views_due.push_back(book_apply(k, p, sz, bid, ss, se));
	endtask

	task automatic wait_book_idle();
		start <= 1'b0;
		while (views_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_field_extremes();
		send_event(lob_pkg::KIND_CLEAR, '0, '0, 1'b0, '0, '0);
		// zero-size snapshot still creates the level
		send_event(lob_pkg::KIND_SNAP, '0, '0, 1'b1, '0, '0);
		send_event(lob_pkg::KIND_SNAP, '1, '1, 1'b0, '0, '0);
		send_event(lob_pkg::KIND_SNAP, '1, '1, 1'b1, '0, '0);
		// ask below bid: negative spread
		send_event(lob_pkg::KIND_SNAP, '0, 40'd1, 1'b0, '0, '0);
		send_event(lob_pkg::KIND_SNAP, '1, 40'd5, 1'b1, '0, '0);
		send_event(lob_pkg::KIND_UPD, '1, '0, 1'b1, '0, 63'd10);
		send_event(lob_pkg::KIND_UPD, 32'd12345, '0, 1'b0, 63'd11, 63'd11);
		send_event(lob_pkg::KIND_UPD, 32'd7, 40'd3, 1'b0, 63'd20, 63'd25);
		send_event(lob_pkg::KIND_SEQ, '1, '1, 1'b1, '1, '1);
		send_event(lob_pkg::KIND_UPD, 32'd8, 40'd9, 1'b1, '1, '0);
		send_event(lob_pkg::KIND_UPD, 32'd9, '1, 1'b0, 63'd5, '1);
		send_event(lob_pkg::KIND_CLEAR, '1, '1, 1'b1, '1, '1);
		send_event(lob_pkg::KIND_UPD, '0, '1, 1'b0, '1, '0);
	endtask

	task automatic test_full_side();
		send_event(lob_pkg::KIND_CLEAR, '0, '0, 1'b0, '0, '0);
		for (int i = 0; i < LEVELS; i++)
			send_event(lob_pkg::KIND_SNAP, 32'd100 + 32'(2 * ((i * 7) % LEVELS)),
				40'(i + 1), 1'b1, '0, '0);
		// worse than the worst bid: refuse
		send_event(lob_pkg::KIND_SNAP, 32'd99, 40'd50, 1'b1, '0, '0);
		// better than the best bid: evict the worst
		send_event(lob_pkg::KIND_UPD, 32'd200, 40'd60, 1'b1, 63'd1, 63'd1);
		send_event(lob_pkg::KIND_UPD, 32'd110, 40'd70, 1'b1, 63'd2, 63'd2);
	endtask

	task automatic test_random_feed(int unsigned count);
		logic [PRICE_W-1:0] mid_px;
		logic [PRICE_W-1:0] px;
		logic [SIZE_W-1:0]  sz;
		logic [SEQ_W-1:0]   next_seq;
		logic [SEQ_W-1:0]   ss;
		logic [SEQ_W-1:0]   se;
		lob_pkg::kind_t     k;
		bit                 bid;
		int unsigned        r;
		mid_px = $urandom;
		next_seq = 63'($urandom_range(1000));
		for (int unsigned n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 2)
				k = lob_pkg::KIND_CLEAR;
			else if (r < 5)
				k = lob_pkg::KIND_SEQ;
			else if (r < 22)
				k = lob_pkg::KIND_SNAP;
			else
				k = lob_pkg::KIND_UPD;
			bid = 1'($urandom_range(1));
			if ($urandom_range(9) == 0)
				px = $urandom;
			else if (bid)
				px = mid_px - 32'($urandom_range(24, 1));
			else
				px = mid_px + 32'($urandom_range(27)) - 32'd3;
			r = $urandom_range(99);
			if (r < (k == lob_pkg::KIND_UPD ? 30 : 10))
				sz = '0;
			else if (r < 80)
				sz = 40'($urandom_range(1000, 1));
			else
				sz = 40'(rand_bits64());
			r = $urandom_range(99);
			if (r < 80)
				ss = next_seq;
			else if (r < 90)
				ss = next_seq + 63'($urandom_range(1000, 1));
			else if (r < 97)
				ss = next_seq - 63'($urandom_range(5));
			else
				ss = 63'(rand_bits64());
			se = $urandom_range(99) < 3 ? 63'(rand_bits64()) : ss + 63'($urandom_range(4));
			send_event(k, px, sz, bid, ss, se);
			case (k)
				lob_pkg::KIND_CLEAR: begin
					r = $urandom_range(9);
					mid_px = r == 0 ? 32'd12 : r == 1 ? 32'hFFFF_FFF0 : $urandom;
					next_seq = 63'($urandom_range(1000));
				end
				lob_pkg::KIND_SEQ, lob_pkg::KIND_UPD: next_seq = se + 63'd1;
				default: ;
			endcase
		end
	endtask

	always @(posedge clk) begin : check_results
		book_view_t want;
		if (arst_n && done) begin
			results_seen++;
			if (views_due.size() == 0) begin
				report_mismatch($sformatf("result %0d with no transaction outstanding",
					results_seen));
			end else begin
				want = views_due.pop_front();
				check_field("bid_valid", 64'(bid_valid), 64'(want.bid_valid));
				check_field("bid_price", 64'(bid_price), 64'(want.bid_price));
				check_field("bid_size", 64'(bid_size), 64'(want.bid_size));
				check_field("ask_valid", 64'(ask_valid), 64'(want.ask_valid));
				check_field("ask_price", 64'(ask_price), 64'(want.ask_price));
				check_field("ask_size", 64'(ask_size), 64'(want.ask_size));
				check_field("spread_ticks", 64'($unsigned(spread_ticks)), 64'(want.spread));
				check_field("mid_doubled", 64'(mid_doubled), 64'(want.mid));
				check_field("gap_total", 64'(gap_total), 64'(want.gaps));
				check_field("level_dropped", 64'(level_dropped), 64'(want.dropped));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[price_level_order_book] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 32;
		test_field_extremes();
		test_full_side();
		test_random_feed(620);
		wait_book_idle();
		idle_pct = 85;
		test_random_feed(620);
		wait_book_idle();
		idle_pct = 0;
		test_random_feed(630);
		wait_book_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("[price_level_order_book] OK");
		end else begin
			$display("[price_level_order_book] ERROR");
		end
		$finish;
	end

endmodule
